// ===== design/multithread_core_scheduler_unit_macros.svh =====
// Assertion macros used by the checker file of the scheduler.
`ifndef MULTITHREAD_CORE_SCHEDULER_UNIT_MACROS_SVH
`define MULTITHREAD_CORE_SCHEDULER_UNIT_MACROS_SVH

// Checked only while the block is out of reset.
`define MCS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define MCS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== design/mcs_pkg.sv =====
// -----------------------------------------------------------------------------
// mcs_pkg
// Shared types, codes and sizes of the multithreaded core scheduler.
// -----------------------------------------------------------------------------
package mcs_pkg;

  localparam int MAX_THREADS     = 8;
  localparam int REGS_PER_THREAD = 8;
  localparam int LINE_BITS       = 16;

  localparam int TID_W  = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
  localparam int RIDX_W = $clog2(REGS_PER_THREAD);
  localparam int TCNT_W = $clog2(MAX_THREADS + 1);

  localparam int IN_DATA_W  = 80;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 200;

  typedef enum logic [1:0] {
    REQ_TICK     = 2'd0,
    REQ_LOAD_RET = 2'd1,
    REQ_REG_READ = 2'd2,
    REQ_NONE     = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    OP_NOP   = 3'd0,
    OP_ADD   = 3'd1,
    OP_SUB   = 3'd2,
    OP_ADDI  = 3'd3,
    OP_SUBI  = 3'd4,
    OP_LOAD  = 3'd5,
    OP_STORE = 3'd6,
    OP_HALT  = 3'd7
  } op_e;

  localparam logic [2:0] CFG_MODE    = 3'd0;
  localparam logic [2:0] CFG_TCOUNT  = 3'd1;
  localparam logic [2:0] CFG_LD_LAT  = 3'd2;
  localparam logic [2:0] CFG_ST_LAT  = 3'd3;
  localparam logic [2:0] CFG_PENALTY = 3'd4;

  localparam logic [1:0] MEM_NONE  = 2'd0;
  localparam logic [1:0] MEM_READ  = 2'd1;
  localparam logic [1:0] MEM_WRITE = 2'd2;

  typedef struct packed {
    req_e              req;
    op_e               op;
    logic [RIDX_W-1:0] dst;
    logic [RIDX_W-1:0] src1;
    logic [RIDX_W-1:0] src2;
    logic [31:0]       src2_imm;
    logic              src2_is_imm;
    logic [TID_W-1:0]  tgt;
    logic [31:0]       ldata;
  } item_t;

  typedef struct packed {
    logic        issued;
    logic [2:0]  ithr;
    logic [1:0]  memop;
    logic [31:0] addr;
    logic [31:0] wdata;
    logic [2:0]  nt;
    logic [15:0] nline;
    logic [8:0]  added;
    logic [31:0] tcyc;
    logic [31:0] tinst;
    logic        halted;
    logic [31:0] regval;
  } result_t;

endpackage

// ===== design/mcs_front.sv =====
// -----------------------------------------------------------------------------
// mcs_front
// Unpacks and classifies input beats and queues them for the back end.
// -----------------------------------------------------------------------------
module mcs_front import mcs_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [IN_DATA_W-1:0] in_data_i,
  input  logic [IN_USER_W-1:0] in_user_i,
  output logic                 q_valid_o,
  output item_t                q_item_o,
  input  logic                 q_pop_i
);

  item_t      dec;
  item_t      slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push;

  // Register indexes wrap modulo the register count, threads modulo the thread count.
  always_comb begin
    dec.req         = req_e'(in_user_i[1:0]);
    dec.op          = op_e'(in_data_i[2:0]);
    dec.dst         = RIDX_W'(in_data_i[5:3] % REGS_PER_THREAD);
    dec.src1        = RIDX_W'(in_data_i[8:6] % REGS_PER_THREAD);
    dec.src2        = RIDX_W'(in_data_i[40:9] % REGS_PER_THREAD);
    dec.src2_imm    = in_data_i[40:9];
    dec.src2_is_imm = in_data_i[41];
    dec.tgt         = TID_W'(in_data_i[44:42] % MAX_THREADS);
    dec.ldata       = in_data_i[76:45];
  end

  assign in_ready_o = (cnt_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_item_o   = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (q_pop_i) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(q_pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) slot_q[wr_ptr_q] <= dec;
  end

endmodule

// ===== design/mcs_back.sv =====
// -----------------------------------------------------------------------------
// mcs_back
// Register read stage, execute and thread scheduling, result register.
// -----------------------------------------------------------------------------
module mcs_back import mcs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_valid_i,
  input  item_t      q_item_i,
  output logic       q_pop_o,
  input  logic       cfg_valid_i,
  input  logic [2:0] cfg_index_i,
  input  logic [7:0] cfg_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output result_t    out_res_o
);

  typedef struct packed {
    logic [TID_W-1:0]  thr;
    logic [RIDX_W-1:0] idx;
    logic [31:0]       data;
  } fwd_t;

  logic       mode_q;
  logic [3:0] tcnt_q;
  logic [7:0] ldlat_q, stlat_q, pen_q;

  logic [MAX_THREADS-1:0] alive_q, alive_d;
  logic [7:0]             wait_q [MAX_THREADS];
  logic [7:0]             wait_d [MAX_THREADS];
  logic [LINE_BITS-1:0]   line_q [MAX_THREADS];
  logic [LINE_BITS-1:0]   line_d [MAX_THREADS];
  logic [TID_W-1:0]       cur_q, cur_d;
  logic [31:0]            cyc_q, cyc_d, inst_q, inst_d;

  // Three copies of the register file, one per read port.
  logic [31:0]                rf_a_q [MAX_THREADS][REGS_PER_THREAD];
  logic [31:0]                rf_b_q [MAX_THREADS][REGS_PER_THREAD];
  logic [31:0]                rf_c_q [MAX_THREADS][REGS_PER_THREAD];
  logic [REGS_PER_THREAD-1:0] rfv_q  [MAX_THREADS];
  logic [31:0]                rd_a_q, rd_b_q, rd_c_q;
  logic                       rd_av_q, rd_bv_q, rd_cv_q;
  logic [TID_W-1:0]           rthr;

  logic    r_valid_q;
  item_t   r_item_q;
  fwd_t    fwd_q;
  logic    fwd_v_q;
  logic    out_valid_q;
  result_t out_q, res_d;

  logic              x_fire, we, we_x;
  logic [TID_W-1:0]  wthr;
  logic [RIDX_W-1:0] widx;
  logic [31:0]       wval;

  assign x_fire  = r_valid_q && (!out_valid_q || out_ready_i);
  assign q_pop_o = q_valid_i && (!r_valid_q || x_fire);
  assign we_x    = x_fire && we;

  always_comb begin
    logic [TCNT_W-1:0]      n;
    logic [MAX_THREADS-1:0] in_use, rdy;
    logic [TID_W-1:0]       cur0, thr_rd, pick, cur_nx;
    logic [TCNT_W:0]        tt;
    logic [31:0]            a, breg, b, dval;
    logic                   halted_pre, issue, found, moved;
    logic [8:0]             added;

    if (tcnt_q == 4'd0) n = TCNT_W'(1);
    else if (int'(tcnt_q) > MAX_THREADS) n = TCNT_W'(MAX_THREADS);
    else n = TCNT_W'(tcnt_q);
    for (int t = 0; t < MAX_THREADS; t++) in_use[t] = (t < int'(n));

    cur0   = (TCNT_W'(cur_q) < n) ? cur_q : '0;
    thr_rd = (r_item_q.req == REQ_TICK) ? cur0 : r_item_q.tgt;

    a = rd_av_q ? rd_a_q : 32'd0;
    if (fwd_v_q && fwd_q.thr == cur0 && fwd_q.idx == r_item_q.src1) a = fwd_q.data;
    breg = rd_bv_q ? rd_b_q : 32'd0;
    if (fwd_v_q && fwd_q.thr == cur0 && fwd_q.idx == r_item_q.src2) breg = fwd_q.data;
    dval = rd_cv_q ? rd_c_q : 32'd0;
    if (fwd_v_q && fwd_q.thr == thr_rd && fwd_q.idx == r_item_q.dst) dval = fwd_q.data;
    b = r_item_q.src2_is_imm ? r_item_q.src2_imm : breg;

    alive_d = alive_q;
    wait_d  = wait_q;
    line_d  = line_q;
    cur_d   = cur_q;
    cyc_d   = cyc_q;
    inst_d  = inst_q;
    res_d   = '0;
    we      = 1'b0;
    wthr    = cur0;
    widx    = r_item_q.dst;
    wval    = 32'd0;
    issue   = 1'b0;
    found   = 1'b0;
    moved   = 1'b0;
    pick    = cur0;
    rdy     = '0;
    tt      = '0;
    added   = 9'd0;

    halted_pre = ~|(alive_q & in_use);

    unique case (r_item_q.req)
      REQ_TICK: begin
        if (!halted_pre) begin
          issue = alive_q[cur0] && (wait_q[cur0] == 8'd0);
          if (issue) begin
            unique case (r_item_q.op)
              OP_ADD, OP_ADDI: begin
                we   = 1'b1;
                wval = a + b;
              end
              OP_SUB, OP_SUBI: begin
                we   = 1'b1;
                wval = a - b;
              end
              OP_LOAD: begin
                res_d.memop  = MEM_READ;
                res_d.addr   = a + b;
                wait_d[cur0] = ldlat_q;
              end
              OP_STORE: begin
                res_d.memop  = MEM_WRITE;
                res_d.addr   = dval + b;
                res_d.wdata  = a;
                wait_d[cur0] = stlat_q;
              end
              OP_HALT: alive_d[cur0] = 1'b0;
              OP_NOP: ;
            endcase
            line_d[cur0] = line_q[cur0] + LINE_BITS'(1);
            inst_d       = inst_q + 32'd1;
            res_d.issued = 1'b1;
            res_d.ithr   = 3'(cur0);
          end
          // Every other live waiting thread has its wait counter decremented by one.
          for (int t = 0; t < MAX_THREADS; t++) begin
            if (in_use[t] && alive_d[t] && !(issue && TID_W'(t) == cur0))
              wait_d[t] = (wait_q[t] != 8'd0) ? wait_q[t] - 8'd1 : 8'd0;
          end
          for (int t = 0; t < MAX_THREADS; t++)
            rdy[t] = in_use[t] && alive_d[t] && (wait_d[t] == 8'd0);
          // Round-robin search from the current thread; fine-grained mode skips it.
          for (int i = 0; i < MAX_THREADS; i++) begin
            if (!found && i < int'(n) && (i != 0 || !mode_q)) begin
              tt = (TCNT_W+1)'(cur0) + (TCNT_W+1)'(i);
              if (tt >= (TCNT_W+1)'(n)) tt = tt - (TCNT_W+1)'(n);
              if (rdy[TID_W'(tt)]) begin
                found = 1'b1;
                pick  = TID_W'(tt);
                moved = (i != 0);
              end
            end
          end
          added = 9'd1;
          cur_d = pick;
          if (found && !mode_q && moved) begin
            added = 9'd1 + {1'b0, pen_q};
            for (int t = 0; t < MAX_THREADS; t++) begin
              if (in_use[t] && alive_d[t])
                wait_d[t] = (wait_d[t] > pen_q) ? wait_d[t] - pen_q : 8'd0;
            end
          end
          cyc_d = cyc_q + 32'(added);
        end
      end
      REQ_LOAD_RET: begin
        we   = 1'b1;
        wthr = r_item_q.tgt;
        wval = r_item_q.ldata;
      end
      REQ_REG_READ: res_d.regval = dval;
      REQ_NONE: ;
    endcase

    res_d.added  = added;
    res_d.nt     = 3'(cur_d);
    res_d.nline  = 16'(line_d[cur_d]);
    res_d.tcyc   = cyc_d;
    res_d.tinst  = inst_d;
    res_d.halted = ~|(alive_d & in_use);

    // The item popped now executes next, on the thread that this edge leaves current.
    cur_nx = x_fire ? cur_d : cur_q;
    if (q_item_i.req == REQ_TICK) rthr = (TCNT_W'(cur_nx) < n) ? cur_nx : '0;
    else rthr = q_item_i.tgt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= 1'b0;
      tcnt_q      <= 4'd8;
      ldlat_q     <= 8'd4;
      stlat_q     <= 8'd4;
      pen_q       <= 8'd2;
      alive_q     <= '1;
      cur_q       <= '0;
      cyc_q       <= 32'd0;
      inst_q      <= 32'd0;
      r_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
      fwd_v_q     <= 1'b0;
      for (int t = 0; t < MAX_THREADS; t++) begin
        wait_q[t] <= 8'd0;
        line_q[t] <= '0;
        rfv_q[t]  <= '0;
      end
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_MODE:    mode_q  <= cfg_data_i[0];
          CFG_TCOUNT:  tcnt_q  <= cfg_data_i[3:0];
          CFG_LD_LAT:  ldlat_q <= cfg_data_i;
          CFG_ST_LAT:  stlat_q <= cfg_data_i;
          CFG_PENALTY: pen_q   <= cfg_data_i;
          default: ;
        endcase
      end
      if (x_fire) begin
        alive_q <= alive_d;
        wait_q  <= wait_d;
        line_q  <= line_d;
        cur_q   <= cur_d;
        cyc_q   <= cyc_d;
        inst_q  <= inst_d;
      end
      if (we_x) begin
        rfv_q[wthr][widx] <= 1'b1;
        fwd_v_q           <= 1'b1;
      end
      if (q_pop_o) r_valid_q <= 1'b1;
      else if (x_fire) r_valid_q <= 1'b0;
      if (x_fire) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) r_item_q <= q_item_i;
    if (x_fire) out_q <= res_d;
    if (we_x) begin
      fwd_q.thr  <= wthr;
      fwd_q.idx  <= widx;
      fwd_q.data <= wval;
    end
  end

  // Register file copies: written at one address, each read at one address,
  // the thread and index of the item being popped.
  always_ff @(posedge clk_i) begin
    if (we_x) begin
      rf_a_q[wthr][widx] <= wval;
      rf_b_q[wthr][widx] <= wval;
      rf_c_q[wthr][widx] <= wval;
    end
    if (q_pop_o) begin
      rd_a_q  <= rf_a_q[rthr][q_item_i.src1];
      rd_b_q  <= rf_b_q[rthr][q_item_i.src2];
      rd_c_q  <= rf_c_q[rthr][q_item_i.dst];
      rd_av_q <= rfv_q[rthr][q_item_i.src1];
      rd_bv_q <= rfv_q[rthr][q_item_i.src2];
      rd_cv_q <= rfv_q[rthr][q_item_i.dst];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

endmodule

// ===== design/multithread_core_scheduler_unit.sv =====
// -----------------------------------------------------------------------------
// multithread_core_scheduler_unit
// Multithreaded in-order core scheduler with blocked and fine-grained modes.
// -----------------------------------------------------------------------------
// The block takes one request beat per clock while results are accepted, and
// returns exactly one result beat for each, in order. A request is a core
// tick carrying the announced thread's instruction, a load data return, or a
// register read. A request is held in a queue slot, then in the register read
// registers, then in the result register; the sustained rate is one beat per
// clock, set by the execute stage, whose thread pick feeds the very next tick.
// A two-entry queue separates the input from the register read stage, and a
// result register separates execute from the output, so a stalled output does
// not immediately stop the input. Configuration writes are always accepted
// and should only be issued while no request is in flight.
module multithread_core_scheduler_unit import mcs_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // opcode, dst_reg, src1_reg, src2_or_imm, src2_is_imm, target_thread,
  // load_data, zero padding
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  // req_type
  input  logic [IN_USER_W-1:0]  s_axis_tuser_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // issued, issued_thread, mem_op, mem_address, mem_write_data, next_thread,
  // next_line, cycles_added, running cycle sum, running instruction sum,
  // all_halted, reg_value, zero padding
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [2:0]            cfg_index_i,
  input  logic [7:0]            cfg_data_i
);

  logic    q_valid, q_pop;
  item_t   q_item;
  result_t res;

  assign cfg_ready_o = 1'b1;

  mcs_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_data_i  (s_axis_tdata_i),
    .in_user_i  (s_axis_tuser_i),
    .q_valid_o  (q_valid),
    .q_item_o   (q_item),
    .q_pop_i    (q_pop)
  );

  mcs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_res_o   (res)
  );

  // Result fields packed from bit zero upward.
  assign m_axis_tdata_o = {5'd0, res.regval, res.halted, res.tinst, res.tcyc,
                           res.added, res.nline, res.nt, res.wdata, res.addr,
                           res.memop, res.ithr, res.issued};

endmodule

// ===== design/mcs_checker.sv =====
// -----------------------------------------------------------------------------
// mcs_checker
// Port-level checks of the scheduler result stream.
// -----------------------------------------------------------------------------
`include "multithread_core_scheduler_unit_macros.svh"

module mcs_checker import mcs_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  m_axis_tvalid_o,
  input logic                  m_axis_tready_i,
  input logic [OUT_DATA_W-1:0] m_axis_tdata_o
);

  `MCS_ASSERT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o, "result beat dropped while stalled")
  `MCS_ASSERT(a_issue_cycles, m_axis_tvalid_o && m_axis_tdata_o[0] |-> m_axis_tdata_o[97:89] != 9'd0, "issued tick added no cycles")
  `MCS_ASSERT(a_mem_needs_issue, m_axis_tvalid_o && !m_axis_tdata_o[0] |-> m_axis_tdata_o[5:4] == MEM_NONE, "memory access without issue")
  `MCS_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |-> !m_axis_tvalid_o, "result valid during reset")

endmodule

bind multithread_core_scheduler_unit mcs_checker u_mcs_checker (.*);
